>>> src/hhbp_pkg.sv
// Package with the types, codes and constants of the HTTP header byte parser.
`timescale 1ns / 1ps

package hhbp_pkg;

   localparam int BYTE_W      = 8;
   localparam int LIMIT_W     = 12;
   localparam int KEY_LEN_W   = 12;
   localparam int VAL_LEN_W   = 13;
   localparam int ROLE_W      = 4;
   localparam int ERR_W       = 3;

   localparam int KEY_COUNT_MAX = 4095;
   localparam int KEY_CNT_W     = $clog2(KEY_COUNT_MAX + 1);
   localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX = KEY_CNT_W'(KEY_COUNT_MAX);

   localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RESET = LIMIT_W'(1024);

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_SKIP     = 4'd0,
      ROLE_KEY      = 4'd1,
      ROLE_COLON    = 4'd2,
      ROLE_SPACE    = 4'd3,
      ROLE_VALUE    = 4'd4,
      ROLE_CR       = 4'd5,
      ROLE_LF_DONE  = 4'd6,
      ROLE_FINAL_CR = 4'd7,
      ROLE_FINAL_LF = 4'd8,
      ROLE_BODY     = 4'd9,
      ROLE_ERROR    = 4'd10
   } role_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_KEY_BREAK = 3'd1,
      ERR_NO_SPACE  = 3'd2,
      ERR_TOO_LONG  = 3'd3,
      ERR_BARE_CR   = 3'd4
   } err_type;

   typedef enum logic [9:0] {
      ST_START  = 10'b00_0000_0001,
      ST_KEY    = 10'b00_0000_0010,
      ST_COLON  = 10'b00_0000_0100,
      ST_SPACE  = 10'b00_0000_1000,
      ST_VALUE  = 10'b00_0001_0000,
      ST_CR     = 10'b00_0010_0000,
      ST_LF     = 10'b00_0100_0000,
      ST_END_CR = 10'b00_1000_0000,
      ST_END_LF = 10'b01_0000_0000,
      ST_ERROR  = 10'b10_0000_0000
   } state_type;

endpackage

>>> src/hhbp_req_if.sv
// Request channel interface carrying one header byte and the restart flag.
`timescale 1ns / 1ps

interface hhbp_req_if;
   import hhbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              restart;

   modport source (output valid, output byte_in, output restart, input ready);
   modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

>>> src/hhbp_rsp_if.sv
// Response channel interface carrying the tagged byte and the field lengths.
`timescale 1ns / 1ps

interface hhbp_rsp_if;
   import hhbp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    byte_out;
   role_type             role;
   err_type              error_kind;
   logic [KEY_LEN_W-1:0] key_length;
   logic [VAL_LEN_W-1:0] value_length;

   modport source (output valid, output byte_out, output role, output error_kind,
                   output key_length, output value_length, input ready);
   modport sink   (input valid, input byte_out, input role, input error_kind,
                   input key_length, input value_length, output ready);
endinterface

>>> src/hhbp_csr_if.sv
// Configuration write channel interface carrying the value limit.
`timescale 1ns / 1ps

interface hhbp_csr_if;
   import hhbp_pkg::*;

   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/http_header_byte_parser_top.sv
// Top level of the HTTP header byte parser: input stage, role state machine, result stage.
// An accepted request is held in the input stage, then in the result stage, before the response.
// One request per cycle unless stalled; state machine and counters update with each byte.
// Stalls on the response channel hold both stages and back-pressure the request channel.
// Reset is synchronous: it empties both stages, clears the parser and sets the limit to 1024.
// Configuration writes are always taken and apply from the next cycle.
`timescale 1ns / 1ps

module http_header_byte_parser_top (
   input logic        clock,
   input logic        reset,
   hhbp_req_if.sink   req_if,
   hhbp_rsp_if.source rsp_if,
   hhbp_csr_if.sink   csr_if
);
   import hhbp_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]    s1_byte_ff;
   logic                 s1_restart_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff;
   role_type             out_role_ff;
   err_type              out_err_ff;
   logic [KEY_LEN_W-1:0] out_klen_ff;
   logic [VAL_LEN_W-1:0] out_vlen_ff;

   state_type            state_ff, state_in;
   logic [KEY_CNT_W-1:0] key_ff, key_in;
   logic [VAL_LEN_W-1:0] val_ff, val_in;
   err_type              err_ff, err_in;
   logic [LIMIT_W-1:0]   limit_ff;

   state_type            cur_state;
   logic [KEY_CNT_W-1:0] cur_key;
   logic [VAL_LEN_W-1:0] cur_val;
   err_type              cur_err;
   role_type             role;
   logic [KEY_LEN_W-1:0] klen;
   logic [VAL_LEN_W-1:0] vlen;
   logic                 brk;

   logic advance;
   logic req_fire;
   logic s1_fire;

   assign advance  = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_fire = req_if.valid && req_if.ready;
   assign s1_fire  = s1_valid_ff && advance;
   assign csr_if.ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
      end
   end

   // A restart acts on the state before the byte is taken.
   always_comb begin
      cur_state = s1_restart_ff ? ST_START : state_ff;
      cur_key   = s1_restart_ff ? '0 : key_ff;
      cur_val   = s1_restart_ff ? '0 : val_ff;
      cur_err   = s1_restart_ff ? ERR_NONE : err_ff;
      state_in  = cur_state;
      key_in    = cur_key;
      val_in    = cur_val;
      err_in    = cur_err;
      role      = ROLE_SKIP;
      klen      = '0;
      vlen      = '0;
      brk       = s1_byte_ff inside {CH_CR, CH_LF};
      case (cur_state)
         ST_START: begin
            if (!brk) begin
               key_in   = KEY_CNT_W'(1);
               val_in   = '0;
               state_in = ST_KEY;
               role     = ROLE_KEY;
            end
         end
         ST_KEY: begin
            if (s1_byte_ff == CH_COLON) begin
               state_in = ST_COLON;
               role     = ROLE_COLON;
            end else if (brk) begin
               err_in   = ERR_KEY_BREAK;
               state_in = ST_ERROR;
               role     = ROLE_ERROR;
            end else begin
               if (cur_key < KEY_CNT_MAX) begin
                  key_in = cur_key + 1'b1;
               end
               role = ROLE_KEY;
            end
         end
         ST_COLON: begin
            if (s1_byte_ff == CH_SPACE) begin
               state_in = ST_SPACE;
               role     = ROLE_SPACE;
            end else begin
               err_in   = ERR_NO_SPACE;
               state_in = ST_ERROR;
               role     = ROLE_ERROR;
            end
         end
         ST_SPACE: begin
            val_in   = VAL_LEN_W'(1);
            state_in = ST_VALUE;
            role     = ROLE_VALUE;
         end
         ST_VALUE: begin
            if (s1_byte_ff == CH_CR) begin
               state_in = ST_CR;
               role     = ROLE_CR;
            end else if (cur_val > {1'b0, limit_ff}) begin
               err_in   = ERR_TOO_LONG;
               state_in = ST_ERROR;
               role     = ROLE_ERROR;
            end else begin
               val_in = cur_val + 1'b1;
               role   = ROLE_VALUE;
            end
         end
         ST_CR: begin
            if (s1_byte_ff == CH_LF) begin
               klen     = KEY_LEN_W'(cur_key);
               vlen     = cur_val;
               state_in = ST_LF;
               role     = ROLE_LF_DONE;
            end else begin
               err_in   = ERR_BARE_CR;
               state_in = ST_ERROR;
               role     = ROLE_ERROR;
            end
         end
         ST_LF: begin
            if (s1_byte_ff == CH_CR) begin
               state_in = ST_END_CR;
               role     = ROLE_FINAL_CR;
            end else begin
               key_in   = KEY_CNT_W'(1);
               val_in   = '0;
               state_in = ST_KEY;
               role     = ROLE_KEY;
            end
         end
         ST_END_CR: begin
            if (s1_byte_ff == CH_LF) begin
               state_in = ST_END_LF;
               role     = ROLE_FINAL_LF;
            end else begin
               err_in   = ERR_BARE_CR;
               state_in = ST_ERROR;
               role     = ROLE_ERROR;
            end
         end
         ST_END_LF: begin
            role = ROLE_BODY;
         end
         default: begin
            state_in = ST_ERROR;
            role     = ROLE_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_START;
         key_ff       <= '0;
         val_ff       <= '0;
         err_ff       <= ERR_NONE;
         limit_ff     <= VALUE_LIMIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_fire) begin
            state_ff <= state_in;
            key_ff   <= key_in;
            val_ff   <= val_in;
            err_ff   <= err_in;
         end
         if (csr_if.valid && csr_if.ready) begin
            limit_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff    <= req_if.byte_in;
         s1_restart_ff <= req_if.restart;
      end
      if (s1_fire) begin
         out_byte_ff <= s1_byte_ff;
         out_role_ff <= role;
         out_err_ff  <= (role == ROLE_ERROR) ? err_in : ERR_NONE;
         out_klen_ff <= klen;
         out_vlen_ff <= vlen;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.byte_out     = out_byte_ff;
   assign rsp_if.role         = out_role_ff;
   assign rsp_if.error_kind   = out_err_ff;
   assign rsp_if.key_length   = out_klen_ff;
   assign rsp_if.value_length = out_vlen_ff;

endmodule

>>> src/hhbp_checker.sv
// Assertion checker on the response ports of the parser, bound to the top level.
`timescale 1ns / 1ps

module hhbp_port_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [hhbp_pkg::BYTE_W-1:0]    rsp_byte_out,
   input hhbp_pkg::role_type             rsp_role,
   input hhbp_pkg::err_type              rsp_error_kind,
   input logic [hhbp_pkg::KEY_LEN_W-1:0] rsp_key_length,
   input logic [hhbp_pkg::VAL_LEN_W-1:0] rsp_value_length
);
   import hhbp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out) && $stable(rsp_role)
         && $stable(rsp_error_kind) && $stable(rsp_key_length) && $stable(rsp_value_length))
      else $error("Stalled response changed.");

   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_role == ROLE_ERROR) == (rsp_error_kind != ERR_NONE)))
      else $error("Error kind does not agree with role.");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_role != ROLE_LF_DONE |-> rsp_key_length == '0 && rsp_value_length == '0)
      else $error("Lengths reported outside a completed field.");

   a_val_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_role == ROLE_LF_DONE |-> rsp_value_length != '0
         && rsp_key_length != '0)
      else $error("Completed field with an empty key or value.");

endmodule

bind http_header_byte_parser_top hhbp_port_checker u_hhbp_port_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_byte_out     (rsp_if.byte_out),
   .rsp_role         (rsp_if.role),
   .rsp_error_kind   (rsp_if.error_kind),
   .rsp_key_length   (rsp_if.key_length),
   .rsp_value_length (rsp_if.value_length)
);
